// File: rtl/fcbp_pkg.sv
// ============================================================================
// fcbp_pkg
// Shared types, constants and the length table lookup for the framed
// command byte parser.
// ============================================================================
package fcbp_pkg;

    // Frame marks.
    localparam logic [7:0] START_MARK = 8'h8A;
    localparam logic [7:0] STOP_MARK  = 8'h51;

    // Length table register.
    localparam int TABLE_W = 48;
    localparam logic [TABLE_W-1:0] TABLE_RESET = 48'd19440801;

    // Payload storage.
    localparam int MAX_PAYLOAD = 7;
    localparam int PAYLOAD_W   = 8 * MAX_PAYLOAD;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_STOP = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;

    // Width of the packed result and of the output tdata bus.
    localparam int RESULT_W = 74;
    localparam int OUT_TDATA_W = 80;

    // One result word, laid out from the highest bit down as on the output bus.
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [2:0]           payload_length;
        logic [7:0]           device_code;
        logic                 diff_flag;
        logic                 echo_req;
        logic                 is_spontaneous;
        logic                 answer_flag;
        logic                 write_req;
        logic [1:0]           status;
    } fcbp_result_t;

    // Payload length of a device code; codes above 15 are unknown.
    function automatic logic [2:0] lookup_length(input logic [TABLE_W-1:0] tbl,
                                                 input logic [7:0] dev);
        logic [2:0] len;
        len = 3'd0;
        if (dev[7:4] == 4'd0)
        begin
            len = tbl[3*dev[3:0] +: 3];
        end
        return len;
    endfunction

endpackage

// File: rtl/fcbp_parser.sv
// ============================================================================
// fcbp_parser
// Frame state machine: tracks the frame phase, keeps the header and payload
// bytes and builds the result on the footer byte.
// ============================================================================
module fcbp_parser
    import fcbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_go,
    input  logic [7:0]         rx_byte,
    input  logic [TABLE_W-1:0] length_table,
    output logic               result_go,
    output fcbp_result_t       result
);

    // Phase codes.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_TYPE   = 3'd1;
    localparam logic [2:0] PH_DEVICE = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_FOOTER = 3'd5;

    logic [2:0]           phase_reg,   phase_next;
    logic [7:0]           type_reg,    type_next;
    logic [7:0]           device_reg,  device_next;
    logic [2:0]           len_reg,     len_next;
    logic [2:0]           cnt_reg,     cnt_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [2:0]           dev_len;

    assign dev_len = lookup_length(length_table, rx_byte);

    // Next-state logic for one accepted word.
    always_comb
    begin
        phase_next   = phase_reg;
        type_next    = type_reg;
        device_next  = device_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        payload_next = payload_reg;
        result_go    = 1'b0;
        if (byte_go)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == START_MARK)
                    begin
                        phase_next   = PH_TYPE;
                        payload_next = '0;
                        cnt_next     = 3'd0;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    phase_next = PH_DEVICE;
                end
                PH_DEVICE:
                begin
                    device_next = rx_byte;
                    len_next    = dev_len;
                    phase_next  = (dev_len == 3'd0) ? PH_SKIP : PH_DATA;
                end
                PH_DATA:
                begin
                    payload_next[8*cnt_reg +: 8] = rx_byte;
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_next == len_reg)
                    begin
                        phase_next = PH_FOOTER;
                    end
                end
                PH_SKIP:
                begin
                    phase_next = PH_FOOTER;
                end
                PH_FOOTER:
                begin
                    result_go  = 1'b1;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Result word, valid while the footer byte is processed.
    always_comb
    begin
        result.payload        = payload_reg;
        result.payload_length = len_reg;
        result.device_code    = device_reg;
        result.diff_flag      = type_reg[7];
        result.echo_req       = type_reg[3];
        result.is_spontaneous = type_reg[2];
        result.answer_flag    = type_reg[1];
        result.write_req      = type_reg[0];
        if (rx_byte != STOP_MARK)
        begin
            result.status = STATUS_BAD_STOP;
        end
        else if (len_reg == 3'd0)
        begin
            result.status = STATUS_UNKNOWN;
        end
        else
        begin
            result.status = STATUS_OK;
        end
    end

    // Phase register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Frame contents.
    always_ff @(posedge clk)
    begin
        type_reg    <= type_next;
        device_reg  <= device_next;
        len_reg     <= len_next;
        cnt_reg     <= cnt_next;
        payload_reg <= payload_next;
    end

endmodule

// File: rtl/framed_command_byte_parser.sv
// ============================================================================
// framed_command_byte_parser
// Parses framed command bytes and reports one result word per frame.
// ============================================================================
// Usage:
//   Received bytes enter on the s_axis channel, one byte per word. A frame is
//   the start byte 0x8A, a type byte, a device byte, the payload bytes whose
//   count comes from the length table, and a footer byte. A device whose
//   table length is zero has one dropped byte before the footer.
//   Each frame gives one result word on the m_axis channel when its footer
//   byte is processed: status, type flags, device, length and payload.
//   The user loads the length table through cfg_we / cfg_data while idle;
//   the block does not enforce this. A byte is held in the input register and
//   parsed into the result register, so a result word is presented once its
//   footer byte has passed through both. Throughput is one byte per cycle
//   while the receiver does not stall, set by the single pass of the parser
//   state machine between the input and result registers.
//   Reset puts the parser in the idle phase, empties both registers and
//   loads the default length table. When the receiver stalls with a result
//   word waiting, the parser holds: the input register takes one more byte
//   and s_axis_tready then stays low until the result word is taken.
// ============================================================================
module framed_command_byte_parser
    import fcbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream. tdata: rx_byte[7:0].
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,
    // Result stream. tdata: status[1:0], write_req[2], answer_flag[3],
    // is_spontaneous[4], echo_req[5], diff_flag[6], device_code[14:7],
    // payload_length[17:15], payload[73:18], zero[79:74].
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Length table write port.
    input  logic                   cfg_we,
    input  logic [TABLE_W-1:0]     cfg_data
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    fcbp_result_t       out_word_reg;
    logic [TABLE_W-1:0] table_reg;
    logic               proc_ok;
    logic               byte_go;
    logic               result_go;
    fcbp_result_t       result;

    // The input register advances whenever the result register can take a word.
    assign proc_ok       = !out_valid_reg || m_axis_tready;
    assign byte_go       = in_valid_reg && proc_ok;
    assign s_axis_tready = !in_valid_reg || proc_ok;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_word_reg};

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Length table register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg <= TABLE_RESET;
        end
        else if (cfg_we)
        begin
            table_reg <= cfg_data;
        end
    end

    // Frame parser.
    fcbp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_go      (byte_go),
        .rx_byte      (in_byte_reg),
        .length_table (table_reg),
        .result_go    (result_go),
        .result       (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_ok)
        begin
            out_valid_reg <= result_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_go)
        begin
            out_word_reg <= result;
        end
    end

endmodule
